// ===== rtl/core/sttok_pkg.sv =====
`timescale 1ns / 1ps
package sttok_pkg;

    localparam int POSITION_BITS_DEF     = 24;
    localparam int KEYWORD_MAX_CHARS_DEF = 11;
    localparam int KIND_BITS             = 6;
    localparam int NUM_KEYWORDS          = 26;
    localparam int KW_CHARS              = 11;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_NUMBER  = 4'd2,
        M_STRING  = 4'd3,
        M_BRACE   = 4'd4,
        M_LINE    = 4'd5,
        M_SLASH   = 4'd6,
        M_COLON   = 4'd7,
        M_LESS    = 4'd8,
        M_GREATER = 4'd9
    } scan_mode_t;

    localparam logic [5:0] K_EOF    = 6'd0;
    localparam logic [5:0] K_IDENT  = 6'd1;
    localparam logic [5:0] K_NUMBER = 6'd2;
    localparam logic [5:0] K_STRING = 6'd3;
    localparam logic [5:0] K_KW0    = 6'd4;
    localparam logic [5:0] K_ASSIGN = 6'd30;
    localparam logic [5:0] K_EQ     = 6'd31;
    localparam logic [5:0] K_NE     = 6'd32;
    localparam logic [5:0] K_LT     = 6'd33;
    localparam logic [5:0] K_GT     = 6'd34;
    localparam logic [5:0] K_LE     = 6'd35;
    localparam logic [5:0] K_GE     = 6'd36;
    localparam logic [5:0] K_PLUS   = 6'd37;
    localparam logic [5:0] K_MINUS  = 6'd38;
    localparam logic [5:0] K_STAR   = 6'd39;
    localparam logic [5:0] K_SLASH  = 6'd40;
    localparam logic [5:0] K_LPAR   = 6'd41;
    localparam logic [5:0] K_RPAR   = 6'd42;
    localparam logic [5:0] K_COMMA  = 6'd43;
    localparam logic [5:0] K_ERROR  = 6'd44;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // keywords, first char in the lowest byte, zero padded
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        {24'h0, "amargorp"}, {40'h0, "oicini"}, {64'h0, "mif"}, {56'h0, "aiel"},
        {32'h0, "avercse"}, {24'h0, "otnauqne"}, {56'h0, "acaf"},
        "otnauqnemif", {56'h0, "arap"}, {72'h0, "ed"}, {64'h0, "eta"},
        {48'h0, "ossap"}, {32'h0, "arapmif"}, {72'h0, "es"}, {48'h0, "oatne"},
        {48'h0, "oanes"}, {48'h0, "esmif"}, {32'h0, "orietni"}, {56'h0, "laer"},
        {16'h0, "eretcarac"}, {24'h0, "onaeloob"}, {8'h0, "oriedadrev"},
        {48'h0, "oslaf"}, {80'h0, "e"}, {72'h0, "uo"}, {64'h0, "oan"}
    };
    localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
        4'd8, 4'd6, 4'd3, 4'd4, 4'd7, 4'd8, 4'd4, 4'd11, 4'd4, 4'd2, 4'd3, 4'd5,
        4'd7, 4'd2, 4'd5, 4'd5, 4'd5, 4'd7, 4'd4, 4'd9, 4'd8, 4'd10, 4'd5, 4'd1,
        4'd2, 4'd3
    };

    typedef struct packed {
        logic       valid;
        logic [5:0] kind;
        logic       at_start;   // start at token_start, else at current byte
        logic       len_one;    // length 1
        logic       len_zero;
        logic       end_next;   // length runs to offset+1, else to offset
    } emit_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction
    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

endpackage

// ===== rtl/core/sttok_kwmatch.sv =====
`timescale 1ns / 1ps
module sttok_kwmatch
    import sttok_pkg::*;
#(
    parameter int KEYWORD_MAX_CHARS = KEYWORD_MAX_CHARS_DEF
) (
    input  logic [KEYWORD_MAX_CHARS*8-1:0] chars,
    input  logic [4:0]                     length,
    input  logic                           too_long,
    output logic [5:0]                     kind
);
    logic [KEYWORD_MAX_CHARS*8-1:0] ref_word;
    always_comb begin
        kind = K_IDENT;
        ref_word = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            ref_word = '0;
            ref_word[KW_CHARS*8-1:0] = KW_TEXT[k];
            if (!too_long && length == {1'b0, KW_LEN[k]} && chars == ref_word)
                kind = K_KW0 + 6'(k);
        end
    end
endmodule

// ===== rtl/core/sttok_scan.sv =====
`timescale 1ns / 1ps
module sttok_scan
    import sttok_pkg::*;
#(
    parameter int KEYWORD_MAX_CHARS = KEYWORD_MAX_CHARS_DEF
) (
    input  scan_mode_t mode,
    input  logic       cmd,
    input  logic [7:0] b,
    input  logic [5:0] ident_kind,
    input  logic [4:0] ident_length,
    output scan_mode_t mode_next,
    output emit_t      e0,
    output emit_t      e1,
    output logic       line_inc,
    output logic       ident_begin,
    output logic       ident_add,
    output logic       ident_over,
    output logic       start_here,
    output logic       err_inc
);
    logic rescan;
    always_comb begin
        mode_next = mode; e0 = '0; e1 = '0; line_inc = 1'b0;
        ident_begin = 1'b0; ident_add = 1'b0; ident_over = 1'b0;
        start_here = 1'b0; err_inc = 1'b0; rescan = 1'b0;
        if (cmd == CMD_END) begin
            e0.valid = 1'b1; e0.at_start = 1'b1;
            case (mode)
                M_IDENT:   e0.kind = ident_kind;
                M_NUMBER:  e0.kind = K_NUMBER;
                M_STRING:  e0.kind = K_STRING;
                M_SLASH:   e0.kind = K_SLASH;
                M_COLON:   begin e0.kind = K_ERROR; e0.len_one = 1'b1; err_inc = 1'b1; end
                M_LESS:    e0.kind = K_LT;
                M_GREATER: e0.kind = K_GT;
                default:   e0.valid = 1'b0;
            endcase
            e1.valid = 1'b1; e1.kind = K_EOF; e1.len_zero = 1'b1;
            mode_next = M_IDLE;
        end else begin
            case (mode)
                M_IDENT: begin
                    if (is_alpha(b) || is_digit(b) || b == "_") begin
                        if (ident_length < 5'(KEYWORD_MAX_CHARS)) ident_add = 1'b1;
                        else ident_over = 1'b1;
                    end else begin
                        e0.valid = 1'b1; e0.kind = ident_kind; e0.at_start = 1'b1;
                        rescan = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (!is_digit(b)) begin
                        e0.valid = 1'b1; e0.kind = K_NUMBER; e0.at_start = 1'b1;
                        rescan = 1'b1;
                    end
                end
                M_STRING: begin
                    line_inc = (b == 8'h0a);
                    if (b == "\"") begin
                        e0.valid = 1'b1; e0.kind = K_STRING; e0.at_start = 1'b1;
                        e0.end_next = 1'b1; mode_next = M_IDLE;
                    end
                end
                M_BRACE: begin
                    line_inc = (b == 8'h0a);
                    if (b == "}") mode_next = M_IDLE;
                end
                M_LINE: begin
                    if (b == 8'h0a) begin line_inc = 1'b1; mode_next = M_IDLE; end
                end
                M_SLASH: begin
                    if (b == "/") mode_next = M_LINE;
                    else begin
                        e0.valid = 1'b1; e0.kind = K_SLASH; e0.at_start = 1'b1;
                        rescan = 1'b1;
                    end
                end
                M_COLON: begin
                    e0.valid = 1'b1; e0.at_start = 1'b1;
                    if (b == "=") begin
                        e0.kind = K_ASSIGN; e0.end_next = 1'b1; mode_next = M_IDLE;
                    end else begin
                        e0.kind = K_ERROR; e0.len_one = 1'b1; err_inc = 1'b1;
                        rescan = 1'b1;
                    end
                end
                M_LESS: begin
                    e0.valid = 1'b1; e0.at_start = 1'b1;
                    if (b == "=") begin
                        e0.kind = K_LE; e0.end_next = 1'b1; mode_next = M_IDLE;
                    end else if (b == ">") begin
                        e0.kind = K_NE; e0.end_next = 1'b1; mode_next = M_IDLE;
                    end else begin
                        e0.kind = K_LT; rescan = 1'b1;
                    end
                end
                M_GREATER: begin
                    e0.valid = 1'b1; e0.at_start = 1'b1;
                    if (b == "=") begin
                        e0.kind = K_GE; e0.end_next = 1'b1; mode_next = M_IDLE;
                    end else begin
                        e0.kind = K_GT; rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
            if (rescan) begin
                mode_next = M_IDLE;
                e1.len_one = 1'b1;
                if (b == 8'h0a) line_inc = 1'b1;
                else if (is_space(b)) begin
                end else if (is_alpha(b) || b == "_") begin
                    mode_next = M_IDENT; start_here = 1'b1; ident_begin = 1'b1;
                end else if (is_digit(b)) begin
                    mode_next = M_NUMBER; start_here = 1'b1;
                end else begin
                    case (b)
                        "{": mode_next = M_BRACE;
                        "/": begin mode_next = M_SLASH; start_here = 1'b1; end
                        "\"": begin mode_next = M_STRING; start_here = 1'b1; end
                        ":": begin mode_next = M_COLON; start_here = 1'b1; end
                        "<": begin mode_next = M_LESS; start_here = 1'b1; end
                        ">": begin mode_next = M_GREATER; start_here = 1'b1; end
                        "=": begin e1.valid = 1'b1; e1.kind = K_EQ; end
                        "+": begin e1.valid = 1'b1; e1.kind = K_PLUS; end
                        "-": begin e1.valid = 1'b1; e1.kind = K_MINUS; end
                        "*": begin e1.valid = 1'b1; e1.kind = K_STAR; end
                        "(": begin e1.valid = 1'b1; e1.kind = K_LPAR; end
                        ")": begin e1.valid = 1'b1; e1.kind = K_RPAR; end
                        ",": begin e1.valid = 1'b1; e1.kind = K_COMMA; end
                        default: begin e1.valid = 1'b1; e1.kind = K_ERROR; err_inc = 1'b1; end
                    endcase
                end
            end
        end
    end
endmodule

// ===== rtl/core/source_text_tokenizer_core.sv =====
`timescale 1ns / 1ps
// channel  dir  tdata (low bit up)                                  tuser  tlast
// s_       in   char_byte[7:0] (tdata 8 bits)                       command  -
// m_       out  kind[5:0] line[P+5:6] start[2P+5:P+6] len[3P+5:2P+6] -      last
// one byte is taken per cycle while s_tready is high; it is decoded and its state updated in the
// same cycle, and its results (up to two) go into a two-entry output queue
// results leave one per cycle while m_tready is high, so a byte with two results holds the next
// byte off until one of them has left, even while the sink takes every transfer
// s_tready is high while the queue is empty or its one entry is leaving
// aresetn clears scan state, counters and the queue
module source_text_tokenizer_core
    import sttok_pkg::*;
#(
    parameter int POSITION_BITS     = POSITION_BITS_DEF,
    parameter int KEYWORD_MAX_CHARS = KEYWORD_MAX_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    // token_kind, line_number, start_offset, token_length
    output logic [((KIND_BITS+3*POSITION_BITS+7)/8)*8-1:0] m_tdata,
    output logic        m_tlast
);
    localparam int P  = POSITION_BITS;
    localparam int OW = KIND_BITS + 3 * P;
    localparam int DW = ((OW + 7) / 8) * 8;
    localparam int LW = $clog2(KEYWORD_MAX_CHARS + 1);

    scan_mode_t mode_reg, mode_next;
    logic [KEYWORD_MAX_CHARS*8-1:0] chars_reg;
    logic [4:0]   len_reg;
    logic         over_reg;
    logic [P-1:0] start_reg, off_reg, line_reg;
    logic [23:0]  err_reg;

    logic [OW:0]  q_reg [2];  // {last, data}
    logic [1:0]   cnt_reg;
    logic [OW:0]  q0_next, q1_next;
    logic [1:0]   cnt_next;

    logic accept;
    assign s_tready = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);
    assign accept = s_tvalid && s_tready;

    logic [5:0] ikind;
    emit_t e0, e1;
    logic line_inc, ib, ia, io, sh, ei;

    sttok_kwmatch #(.KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)) u_kw (
        .chars(chars_reg), .length(len_reg), .too_long(over_reg), .kind(ikind));

    sttok_scan #(.KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS)) u_scan (
        .mode(mode_reg), .cmd(s_tuser), .b(s_tdata), .ident_kind(ikind),
        .ident_length(len_reg), .mode_next(mode_next), .e0(e0), .e1(e1),
        .line_inc(line_inc), .ident_begin(ib), .ident_add(ia), .ident_over(io),
        .start_here(sh), .err_inc(ei));

    logic [P-1:0] p1, line_pre;
    assign p1 = off_reg + 1'b1;
    // e0 sees the line count before the byte, e1 after it
    assign line_pre = line_reg;
    logic [P-1:0] line_post;
    assign line_post = (line_inc && line_reg != {P{1'b1}}) ? line_reg + 1'b1 : line_reg;

    function automatic logic [OW-1:0] pack(input emit_t e, input logic [P-1:0] ln,
                                           input logic [P-1:0] st, input logic [P-1:0] of,
                                           input logic [P-1:0] of1);
        logic [P-1:0] s, l;
        s = e.at_start ? st : of;
        if (e.len_zero) l = '0;
        else if (e.len_one) l = P'(1);
        else l = (e.end_next ? of1 : of) - st;
        return {l, s, ln, e.kind};
    endfunction

    logic [OW-1:0] d0, d1;
    assign d0 = pack(e0, line_pre, start_reg, off_reg, p1);
    assign d1 = pack(e1, line_post, start_reg, off_reg, p1);

    logic [OW:0] first, second;
    logic [1:0]  n_new;
    always_comb begin
        n_new = 2'(e0.valid) + 2'(e1.valid);
        first  = e0.valid ? {!e1.valid, d0} : {1'b1, d1};
        second = {1'b1, d1};
    end

    logic pop;
    assign pop = m_tvalid && m_tready;

    // output queue: entry 0 is the head
    always_comb begin
        q0_next = q_reg[0];
        q1_next = q_reg[1];
        cnt_next = cnt_reg;
        if (pop) begin
            q0_next = q_reg[1];
            cnt_next = cnt_reg - 2'd1;
        end
        if (accept && n_new != 2'd0) begin
            if (cnt_next == 2'd0) begin
                q0_next = first;
                if (n_new == 2'd2) q1_next = second;
            end else q1_next = first;
        end
        if (accept) cnt_next = cnt_next + n_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE; chars_reg <= '0; len_reg <= '0; over_reg <= 1'b0;
            start_reg <= '0; off_reg <= '0; line_reg <= P'(1); err_reg <= '0;
            cnt_reg <= '0;
        end else begin
            q_reg[0] <= q0_next;
            q_reg[1] <= q1_next;
            cnt_reg  <= cnt_next;
            if (accept) begin
                if (s_tuser == CMD_END) begin
                    mode_reg <= M_IDLE; chars_reg <= '0; len_reg <= '0; over_reg <= 1'b0;
                    start_reg <= '0; off_reg <= '0; line_reg <= P'(1); err_reg <= '0;
                end else begin
                    mode_reg <= mode_next;
                    off_reg  <= p1;
                    line_reg <= line_post;
                    if (sh) start_reg <= off_reg;
                    if (ei && err_reg != 24'hFFFFFF) err_reg <= err_reg + 1'b1;
                    if (ib) begin
                        chars_reg <= {{(KEYWORD_MAX_CHARS-1)*8{1'b0}}, s_tdata};
                        len_reg <= 5'd1; over_reg <= 1'b0;
                    end else if (ia) begin
                        chars_reg[len_reg[LW-1:0]*8 +: 8] <= s_tdata;
                        len_reg <= len_reg + 1'b1;
                    end else if (io) over_reg <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tdata  = DW'(q_reg[0][OW-1:0]);
    assign m_tlast  = q_reg[0][OW];
endmodule
